>>> rtl/wfpa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the worst-fit partition allocator.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package wfpa_pkg;

	// Default sizes of the hole table.
	localparam int NUM_HOLES_DEF = 16;
	localparam int SIZE_BITS_DEF = 16;

	// Fixed field widths on the channels.
	localparam int HOLE_COUNT_W = 5;
	localparam int HOLE_IDX_W   = 4;
	localparam int SIZE_W       = 16;

	// Opcode values on the input channel.
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	// Kind of work that the front end has recognized.
	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_REQUEST = 1'b1
	} kind_t;

	// One entry of the queue between front end and back end.
	typedef struct packed {
		kind_t                  kind;
		logic                   in_range;
		logic [HOLE_IDX_W-1:0]  hole_index;
		logic [SIZE_W-1:0]      size;
	} queue_entry_t;

endpackage

>>> rtl/wfpa_item_if.sv
`timescale 1ns / 1ps
// Input channel of the allocator: valid/ready with one opcode, hole index and size.
// Depends on wfpa_pkg for the field widths.
interface wfpa_item_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [wfpa_pkg::HOLE_IDX_W-1:0]  hole_index;
	logic [wfpa_pkg::SIZE_W-1:0]      size;

	modport source (output valid, output opcode, output hole_index, output size, input ready);
	modport sink (input valid, input opcode, input hole_index, input size, output ready);
endinterface

>>> rtl/wfpa_result_if.sv
`timescale 1ns / 1ps
// Result channel of the allocator: valid/ready with grant, hole, remainder and status.
// Depends on wfpa_pkg for the field widths.
interface wfpa_result_if;
	logic                             valid;
	logic                             ready;
	logic                             granted;
	logic [wfpa_pkg::HOLE_IDX_W-1:0]  chosen_hole;
	logic [wfpa_pkg::SIZE_W-1:0]      remaining;
	logic                             all_placed;

	modport source (output valid, output granted, output chosen_hole, output remaining,
		output all_placed, input ready);
	modport sink (input valid, input granted, input chosen_hole, input remaining,
		input all_placed, output ready);
endinterface

>>> rtl/wfpa_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready carrying the hole count.
// Depends on wfpa_pkg for the register width.
interface wfpa_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [wfpa_pkg::HOLE_COUNT_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/wfpa_front.sv
`timescale 1ns / 1ps
// Front end: takes input transactions, decodes the opcode and checks the load index.
// Depends on wfpa_pkg and wfpa_item_if; feeds wfpa_queue.
module wfpa_front #(
	parameter int NUM_HOLES = wfpa_pkg::NUM_HOLES_DEF
) (
	wfpa_item_if.sink                  item,
	input  logic                       q_full,
	output logic                       q_push,
	output wfpa_pkg::queue_entry_t     q_entry
);

	// A transaction is taken whenever the queue has room.
	assign item.ready = !q_full;
	assign q_push     = item.valid && !q_full;

	// Classify the item and flag loads that address a hole outside the table.
	always_comb begin
		q_entry.kind       = (item.opcode == wfpa_pkg::OP_REQUEST) ?
			wfpa_pkg::KIND_REQUEST : wfpa_pkg::KIND_LOAD;
		q_entry.in_range   = (32'(item.hole_index) < NUM_HOLES);
		q_entry.hole_index = item.hole_index;
		q_entry.size       = item.size;
	end

endmodule

>>> rtl/wfpa_queue.sv
`timescale 1ns / 1ps
// Two-entry queue that decouples the front end from the back end.
// Depends on wfpa_pkg for the entry type.
module wfpa_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  wfpa_pkg::queue_entry_t  push_entry,
	output logic                    full,
	input  logic                    pop,
	output wfpa_pkg::queue_entry_t  head,
	output logic                    empty
);

	wfpa_pkg::queue_entry_t entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entries_q[rd_ptr_q];

	// Entry storage carries no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// The neighbors never push into a full queue or pop an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue popped while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue count did not follow a push");

endmodule

>>> rtl/wfpa_back.sv
`timescale 1ns / 1ps
// Back end: hole table memory, used marks, worst-fit scan and the result register.
// Depends on wfpa_pkg and wfpa_result_if; is fed by wfpa_queue.
module wfpa_back #(
	parameter int NUM_HOLES = wfpa_pkg::NUM_HOLES_DEF,
	parameter int SIZE_BITS = wfpa_pkg::SIZE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  wfpa_pkg::queue_entry_t               q_head,
	output logic                                 q_pop,
	input  logic [wfpa_pkg::HOLE_COUNT_W-1:0]    hole_count,
	wfpa_result_if.source                        result
);

	localparam int HIDX_W = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
	localparam int CNT_W  = $clog2(NUM_HOLES + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	// Hole table and its marks.
	logic [SIZE_BITS-1:0] hole_mem [NUM_HOLES];
	logic [NUM_HOLES-1:0] used_q;

	state_t               st_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     lim_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 found_q;
	logic [HIDX_W-1:0]    best_q;
	logic [SIZE_BITS-1:0] best_rem_q;
	logic                 any_refused_q;

	// Scan pipeline: table read data and the mark of the same hole.
	logic                 valid_s1;
	logic                 used_s1;
	logic [HIDX_W-1:0]    idx_s1;
	logic [SIZE_BITS-1:0] rdata_s1;

	// Result register.
	logic                          out_valid_q;
	logic                          out_granted_q;
	logic [wfpa_pkg::HOLE_IDX_W-1:0] out_hole_q;
	logic [wfpa_pkg::SIZE_W-1:0]   out_rem_q;
	logic                          out_all_q;

	logic                 out_free;
	logic                 is_load;
	logic [SIZE_BITS-1:0] head_size;
	logic [HIDX_W-1:0]    head_idx;
	logic [CNT_W-1:0]     lim_next;
	logic                 issue;
	logic [HIDX_W-1:0]    rd_idx;
	logic                 fit;
	logic [SIZE_BITS-1:0] diff;
	logic                 take;
	logic                 finish_go;
	logic                 mem_we;
	logic [HIDX_W-1:0]    mem_waddr;
	logic [SIZE_BITS-1:0] mem_wdata;

	// Decode of the queue head and the issue of the next table read.
	always_comb begin
		out_free  = !out_valid_q || result.ready;
		is_load   = (q_head.kind == wfpa_pkg::KIND_LOAD);
		head_size = SIZE_BITS'(q_head.size);
		head_idx  = HIDX_W'(q_head.hole_index);
		q_pop     = (st_q == ST_IDLE) && !q_empty && (!is_load || out_free);
		if (32'(hole_count) > NUM_HOLES) begin
			lim_next = CNT_W'(NUM_HOLES);
		end else begin
			lim_next = CNT_W'(hole_count);
		end
		issue  = (st_q == ST_SCAN) && (cnt_q < lim_q);
		rd_idx = cnt_q[HIDX_W-1:0];
	end

	// Worst-fit compare on the hole that came out of the table this cycle.
	always_comb begin
		fit  = valid_s1 && !used_s1 && (size_q <= rdata_s1);
		diff = rdata_s1 - size_q;
		take = fit && (!found_q || (diff > best_rem_q));
	end

	// One write port, shared by loads and by the final update of a request.
	always_comb begin
		finish_go = (st_q == ST_FINISH) && out_free;
		if (st_q == ST_IDLE) begin
			mem_we    = q_pop && is_load && q_head.in_range;
			mem_waddr = head_idx;
			mem_wdata = head_size;
		end else begin
			mem_we    = finish_go && found_q;
			mem_waddr = best_q;
			mem_wdata = best_rem_q;
		end
	end

	// Hole table memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hole_mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= hole_mem[rd_idx];
	end

	// Payload registers of the scan and the result.
	always_ff @(posedge clk) begin
		used_s1 <= used_q[rd_idx];
		idx_s1  <= rd_idx;
		if (q_pop && !is_load) begin
			lim_q  <= lim_next;
			size_q <= head_size;
		end
		if (take) begin
			best_q     <= idx_s1;
			best_rem_q <= diff;
		end
		if (q_pop && is_load) begin
			out_granted_q <= 1'b0;
			out_hole_q    <= q_head.hole_index;
			out_rem_q     <= wfpa_pkg::SIZE_W'(head_size);
			out_all_q     <= !any_refused_q;
		end else if (finish_go) begin
			out_granted_q <= found_q;
			out_hole_q    <= found_q ? wfpa_pkg::HOLE_IDX_W'(best_q) : '0;
			out_rem_q     <= found_q ? wfpa_pkg::SIZE_W'(best_rem_q) : '0;
			out_all_q     <= found_q && !any_refused_q;
		end
	end

	// Sequencer, marks and sticky refusal flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			cnt_q         <= '0;
			found_q       <= 1'b0;
			valid_s1      <= 1'b0;
			used_q        <= '0;
			any_refused_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (take) begin
				found_q <= 1'b1;
			end
			if ((q_pop && is_load) || finish_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (is_load) begin
							if (q_head.in_range) begin
								used_q[head_idx] <= 1'b0;
							end
						end else begin
							st_q    <= ST_SCAN;
							cnt_q   <= '0;
							found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						st_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						if (found_q) begin
							used_q[best_q] <= 1'b1;
						end else begin
							any_refused_q <= 1'b1;
						end
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.granted     = out_granted_q;
	assign result.chosen_hole = out_hole_q;
	assign result.remaining   = out_rem_q;
	assign result.all_placed  = out_all_q;

	// The scan counter never runs past the latched limit.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> (cnt_q <= lim_q)) else $error("scan ran past the limit");
	// A granted hole lies inside the scanned range.
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(finish_go && found_q) |-> (32'(best_q) < 32'(lim_q)))
		else $error("chosen hole outside the scanned range");
	// Once refused, the failure flag stays set.
	a_refused_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		any_refused_q |=> any_refused_q) else $error("failure flag cleared");
	// A load leaves a result waiting in the next cycle.
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && is_load) |=> out_valid_q) else $error("load gave no result");

endmodule

>>> rtl/worst_fit_partition_allocator.sv
`timescale 1ns / 1ps
// Top level of the worst-fit partition allocator: configuration register and the
// front end, queue and back end. Depends on wfpa_pkg, the interfaces and all modules.
//
//   channel  | dir | payload                                   | handshake
//   item     | in  | opcode, hole_index, size                  | valid/ready
//   result   | out | granted, chosen_hole, remaining, all_plcd | valid/ready
//   cfg      | in  | data (hole_count)                         | valid/ready, ready tied 1
//
// A load passes through the queue; once popped it writes the hole table and the result.
// A request scans hole_count holes (clamped to NUM_HOLES), then updates the table: the scan
// reads one hole per cycle through the single read port of the hole table.
// Reset clears the marks, the failure flag, the queue and the sequencer; sizes are kept
// uninitialized. The front end keeps taking items into a two-entry queue while the back end
// works or waits on a stalled result; a full queue drops item.ready.
module worst_fit_partition_allocator #(
	parameter int NUM_HOLES = wfpa_pkg::NUM_HOLES_DEF,
	parameter int SIZE_BITS = wfpa_pkg::SIZE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	wfpa_item_if.sink      item,
	wfpa_result_if.source  result,
	wfpa_cfg_if.sink       cfg
);

	logic [wfpa_pkg::HOLE_COUNT_W-1:0] hole_count_q;
	logic                              q_full;
	logic                              q_empty;
	logic                              q_push;
	logic                              q_pop;
	wfpa_pkg::queue_entry_t            q_entry;
	wfpa_pkg::queue_entry_t            q_head;

	// Hole count register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_count_q <= '0;
		end else if (cfg.valid) begin
			hole_count_q <= cfg.data;
		end
	end

	wfpa_front #(
		.NUM_HOLES (NUM_HOLES)
	) u_front (
		.item    (item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	wfpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	wfpa_back #(
		.NUM_HOLES (NUM_HOLES),
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.hole_count (hole_count_q),
		.result     (result)
	);

endmodule
